/* rtl/core/emuc_pkg.sv */
`default_nettype none
package emuc_pkg;

  // Day split, calendar and time-of-day constants
  localparam logic [47:0] LIMIT_MS     = 48'd253402300800000;
  localparam logic [26:0] MS_PER_DAY   = 27'd86400000;
  localparam logic [9:0]  MS_PER_SEC   = 10'd1000;
  localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SEC_PER_MIN  = 6'd60;
  localparam logic [21:0] DAYS_TO_0301 = 22'd719468;
  localparam logic [17:0] DAYS_PER_ERA = 18'd146097;
  localparam int unsigned DAYS_PER_CENT = 36524;
  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
  localparam logic [13:0] YEARS_PER_ERA = 14'd400;

  // Reciprocal multipliers. Exact ones use M = ceil(2^s/D) with
  // s = dividend bits + ceil(log2 D). The day estimate is floor-based
  // and is fixed up by one compare-subtract.
  localparam int unsigned DAY_QSH  = 34;
  localparam logic [23:0] DAY_MUL  = 24'((64'd1 << (DAY_QSH + 16)) / 64'd86400000);

  localparam int unsigned ERA_SHIFT = 40;
  localparam logic [22:0] ERA_MUL   = 23'(((64'd1 << ERA_SHIFT) + 64'd146096) / 64'd146097);

  localparam int unsigned Q1460_SHIFT = 29;
  localparam logic [18:0] Q1460_MUL   = 19'(((64'd1 << Q1460_SHIFT) + 64'd1459) / 64'd1460);

  localparam int unsigned YOE_SHIFT = 27;
  localparam logic [18:0] YOE_MUL   = 19'(((64'd1 << YOE_SHIFT) + 64'd364) / 64'd365);

  localparam int unsigned MP_SHIFT = 19;
  localparam logic [11:0] MP_MUL   = 12'(((64'd1 << MP_SHIFT) + 64'd152) / 64'd153);

  localparam int unsigned SEC_SHIFT = 31;
  localparam logic [24:0] SEC_MUL   = 25'(((64'd1 << SEC_SHIFT) + 64'd124) / 64'd125);

  localparam int unsigned HOUR_SHIFT = 21;
  localparam logic [13:0] HOUR_MUL   = 14'(((64'd1 << HOUR_SHIFT) + 64'd224) / 64'd225);

  localparam int unsigned MIN_SHIFT = 14;
  localparam logic [10:0] MIN_MUL   = 11'(((64'd1 << MIN_SHIFT) + 64'd14) / 64'd15);

  // Pipeline depths
  localparam int unsigned SPLIT_LAT = 3;
  localparam int unsigned CIV_LAT   = 8;
  localparam int unsigned TOD_LAT   = 5;
  localparam int unsigned TOD_PAD   = CIV_LAT - TOD_LAT;
  localparam int unsigned OUT_TAP   = SPLIT_LAT + CIV_LAT;

  typedef struct packed {
    logic vld;
    logic inr;
  } ctl_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } civ_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [9:0] millisecond;
  } tod_t;

  // Day-of-year where each March-based month starts: (153*mp + 2) / 5
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] res;
    case (mp)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd92;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd153;
      4'd6:    res = 9'd184;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd245;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd306;
      4'd11:   res = 9'd337;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/epoch_msec_to_utc_calendar.sv */
// Millisecond epoch count to UTC calendar fields. A request is taken on
// every clock where start is high; busy never rises, so one timestamp per
// cycle is converted. Each result is flagged by a one-cycle out_valid
// pulse and results come back in request order. There is no flow control
// on the result side: the receiver must capture every strobed result.
// The work is split into short stages, each built around one reciprocal
// multiplier (day split, 400-year era, 1460-day quotient, year of era,
// month, second, hour, minute) or a small constant multiply-subtract.
// Timestamps from year 10000 on return out_valid_res = 0 with all fields 0.
`default_nettype none
module epoch_msec_to_utc_calendar (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [47:0] in_timestamp_ms,
  output logic             busy,
  output logic             out_valid,
  output logic [13:0]      out_year,
  output logic [3:0]       out_month,
  output logic [4:0]       out_day,
  output logic [4:0]       out_hour,
  output logic [5:0]       out_minute,
  output logic [5:0]       out_second,
  output logic [9:0]       out_millisecond,
  output logic             out_valid_res
);

  emuc_pkg::ctl_t ctl_r   [emuc_pkg::OUT_TAP];
  emuc_pkg::ctl_t ctl_nxt [emuc_pkg::OUT_TAP];

  logic [55:0] day_prod;
  logic [21:0] qe1_r, qe1_nxt;
  logic [27:0] tsl1_r;
  logic [21:0] q2_r;
  logic [27:0] tsl2_r;
  logic [27:0] pl2_r, pl2_nxt;
  logic [27:0] rem;
  logic        corr;
  logic [21:0] z3_r, z3_nxt;
  logic [26:0] msd3_r, msd3_nxt;

  emuc_pkg::civ_t civ;
  emuc_pkg::tod_t tod;

  logic        out_valid_r;
  logic        valid_res_r;
  logic [13:0] year_r;
  logic [3:0]  month_r;
  logic [4:0]  day_r;
  logic [4:0]  hour_r;
  logic [5:0]  minute_r;
  logic [5:0]  second_r;
  logic [9:0]  ms_r;
  logic        inr;

  assign busy = 1'b0;

  always_comb begin
    ctl_nxt[0].vld = start && !busy;
    ctl_nxt[0].inr = in_timestamp_ms < emuc_pkg::LIMIT_MS;
    for (int i = 1; i < emuc_pkg::OUT_TAP; i++) begin
      ctl_nxt[i] = ctl_r[i-1];
    end
  end

  always_comb begin
    // Estimate from the top 32 bits; it is at most one day low
    day_prod = 56'(in_timestamp_ms[47:16]) * 56'(emuc_pkg::DAY_MUL);
    qe1_nxt  = day_prod[emuc_pkg::DAY_QSH +: 22];

    // remainder stays below two days, so 28 low bits are enough
    pl2_nxt = 28'(qe1_r) * 28'(emuc_pkg::MS_PER_DAY);

    rem      = tsl2_r - pl2_r;
    corr     = rem >= 28'(emuc_pkg::MS_PER_DAY);
    msd3_nxt = corr ? 27'(rem - 28'(emuc_pkg::MS_PER_DAY)) : 27'(rem);
    z3_nxt   = q2_r + 22'(corr) + emuc_pkg::DAYS_TO_0301;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < emuc_pkg::OUT_TAP; i++) begin
        ctl_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < emuc_pkg::OUT_TAP; i++) begin
        ctl_r[i] <= ctl_nxt[i];
      end
      out_valid_r <= ctl_r[emuc_pkg::OUT_TAP-1].vld;
    end
  end

  always_ff @(posedge clk) begin
    qe1_r  <= qe1_nxt;
    tsl1_r <= in_timestamp_ms[27:0];
    q2_r   <= qe1_r;
    tsl2_r <= tsl1_r;
    pl2_r  <= pl2_nxt;
    z3_r   <= z3_nxt;
    msd3_r <= msd3_nxt;
  end

  emuc_civil u_civil (
    .clk (clk),
    .z   (z3_r),
    .civ (civ)
  );

  emuc_tod u_tod (
    .clk (clk),
    .msd (msd3_r),
    .tod (tod)
  );

  assign inr = ctl_r[emuc_pkg::OUT_TAP-1].inr;

  always_ff @(posedge clk) begin
    valid_res_r <= inr;
    year_r      <= inr ? civ.year : '0;
    month_r     <= inr ? civ.month : '0;
    day_r       <= inr ? civ.day : '0;
    hour_r      <= inr ? tod.hour : '0;
    minute_r    <= inr ? tod.minute : '0;
    second_r    <= inr ? tod.second : '0;
    ms_r        <= inr ? tod.millisecond : '0;
  end

  assign out_valid       = out_valid_r;
  assign out_valid_res   = valid_res_r;
  assign out_year        = year_r;
  assign out_month       = month_r;
  assign out_day         = day_r;
  assign out_hour        = hour_r;
  assign out_minute      = minute_r;
  assign out_second      = second_r;
  assign out_millisecond = ms_r;

endmodule
`default_nettype wire

/* rtl/core/emuc_tod.sv */
`default_nettype none
module emuc_tod (
  input  wire logic        clk,
  input  wire logic [26:0] msd,
  output emuc_pkg::tod_t   tod
);

  logic [26:0] dly_r [emuc_pkg::TOD_PAD];

  logic [16:0] secs1_r, secs1_nxt;
  logic [9:0]  msl1_r;
  logic [16:0] secs2_r;
  logic [4:0]  hour2_r, hour2_nxt;
  logic [9:0]  ms2_r, ms2_nxt;
  logic [11:0] soh3_r, soh3_nxt;
  logic [4:0]  hour3_r;
  logic [9:0]  ms3_r;
  logic [5:0]  min4_r, min4_nxt;
  logic [11:0] soh4_r;
  logic [4:0]  hour4_r;
  logic [9:0]  ms4_r;
  emuc_pkg::tod_t tod_r, tod_nxt;

  logic [48:0] sec_prod;
  logic [26:0] hour_prod;
  logic [20:0] min_prod;
  logic [26:0] msd_d;

  assign msd_d = dly_r[emuc_pkg::TOD_PAD-1];

  always_comb begin
    sec_prod  = 49'(msd_d[26:3]) * 49'(emuc_pkg::SEC_MUL);
    secs1_nxt = sec_prod[emuc_pkg::SEC_SHIFT +: 17];

    hour_prod = 27'(secs1_r[16:4]) * 27'(emuc_pkg::HOUR_MUL);
    hour2_nxt = hour_prod[emuc_pkg::HOUR_SHIFT +: 5];
    // remainder fits in 10 bits, so only the low product bits matter
    ms2_nxt   = msl1_r - secs1_r[9:0] * emuc_pkg::MS_PER_SEC;

    soh3_nxt  = secs2_r[11:0] - 12'(hour2_r) * emuc_pkg::SEC_PER_HOUR;

    min_prod  = 21'(soh3_r[11:2]) * 21'(emuc_pkg::MIN_MUL);
    min4_nxt  = min_prod[emuc_pkg::MIN_SHIFT +: 6];

    tod_nxt.hour        = hour4_r;
    tod_nxt.minute      = min4_r;
    tod_nxt.second      = soh4_r[5:0] - min4_r * emuc_pkg::SEC_PER_MIN;
    tod_nxt.millisecond = ms4_r;
  end

  always_ff @(posedge clk) begin
    dly_r[0] <= msd;
    for (int i = 1; i < emuc_pkg::TOD_PAD; i++) begin
      dly_r[i] <= dly_r[i-1];
    end
    secs1_r <= secs1_nxt;
    msl1_r  <= msd_d[9:0];
    secs2_r <= secs1_r;
    hour2_r <= hour2_nxt;
    ms2_r   <= ms2_nxt;
    soh3_r  <= soh3_nxt;
    hour3_r <= hour2_r;
    ms3_r   <= ms2_r;
    min4_r  <= min4_nxt;
    soh4_r  <= soh3_r;
    hour4_r <= hour3_r;
    ms4_r   <= ms3_r;
    tod_r   <= tod_nxt;
  end

  assign tod = tod_r;

endmodule
`default_nettype wire

/* rtl/core/emuc_civil.sv */
`default_nettype none
module emuc_civil (
  input  wire logic        clk,
  input  wire logic [21:0] z,
  output emuc_pkg::civ_t   civ
);

  logic [4:0]  era1_r, era1_nxt;
  logic [17:0] z1_r;
  logic [17:0] doe2_r, doe2_nxt;
  logic [4:0]  era2_r;
  logic [6:0]  a3_r, a3_nxt;
  logic [1:0]  nb3_r, nb3_nxt;
  logic [17:0] doe3_r;
  logic [4:0]  era3_r;
  logic [17:0] x4_r, x4_nxt;
  logic [8:0]  doe4_r;
  logic [4:0]  era4_r;
  logic [8:0]  yoe5_r, yoe5_nxt;
  logic [8:0]  doe5_r;
  logic [4:0]  era5_r;
  logic [8:0]  doy6_r, doy6_nxt;
  logic [13:0] yb6_r, yb6_nxt;
  logic [3:0]  mp7_r, mp7_nxt;
  logic [8:0]  doy7_r;
  logic [13:0] yb7_r;
  emuc_pkg::civ_t civ_r, civ_nxt;

  logic [44:0] era_prod;
  logic [36:0] a_prod;
  logic [36:0] yoe_prod;
  logic [1:0]  ycent;
  logic [10:0] mp_num;
  logic [22:0] mp_prod;
  logic        jan_feb;

  always_comb begin
    era_prod = 45'(z) * 45'(emuc_pkg::ERA_MUL);
    era1_nxt = era_prod[emuc_pkg::ERA_SHIFT +: 5];

    doe2_nxt = z1_r - 18'(era1_r) * emuc_pkg::DAYS_PER_ERA;

    a_prod  = 37'(doe2_r) * 37'(emuc_pkg::Q1460_MUL);
    a3_nxt  = a_prod[emuc_pkg::Q1460_SHIFT +: 7];
    // doe/36524 - doe/146096: the last day of an era counts only once
    nb3_nxt = 2'(doe2_r >= 18'(emuc_pkg::DAYS_PER_CENT))
            + 2'(doe2_r >= 18'(2 * emuc_pkg::DAYS_PER_CENT))
            + 2'(doe2_r >= 18'(3 * emuc_pkg::DAYS_PER_CENT));

    x4_nxt = doe3_r - 18'(a3_r) + 18'(nb3_r);

    yoe_prod = 37'(x4_r) * 37'(emuc_pkg::YOE_MUL);
    yoe5_nxt = yoe_prod[emuc_pkg::YOE_SHIFT +: 9];

    ycent    = 2'(yoe5_r >= 9'd100) + 2'(yoe5_r >= 9'd200) + 2'(yoe5_r >= 9'd300);
    doy6_nxt = doe5_r - (yoe5_r * emuc_pkg::DAYS_PER_YEAR + (yoe5_r >> 2) - 9'(ycent));
    yb6_nxt  = 14'(yoe5_r) + 14'(era5_r) * emuc_pkg::YEARS_PER_ERA;

    mp_num  = {doy6_r, 2'b00} + 11'(doy6_r) + 11'd2;
    mp_prod = 23'(mp_num) * 23'(emuc_pkg::MP_MUL);
    mp7_nxt = mp_prod[emuc_pkg::MP_SHIFT +: 4];

    // March-based months 10 and 11 are January and February of the next year
    jan_feb       = mp7_r >= 4'd10;
    civ_nxt.month = jan_feb ? mp7_r - 4'd9 : mp7_r + 4'd3;
    civ_nxt.year  = yb7_r + 14'(jan_feb);
    civ_nxt.day   = 5'(doy7_r - emuc_pkg::month_start(mp7_r) + 9'd1);
  end

  always_ff @(posedge clk) begin
    era1_r <= era1_nxt;
    z1_r   <= z[17:0];
    doe2_r <= doe2_nxt;
    era2_r <= era1_r;
    a3_r   <= a3_nxt;
    nb3_r  <= nb3_nxt;
    doe3_r <= doe2_r;
    era3_r <= era2_r;
    x4_r   <= x4_nxt;
    doe4_r <= doe3_r[8:0];
    era4_r <= era3_r;
    yoe5_r <= yoe5_nxt;
    doe5_r <= doe4_r;
    era5_r <= era4_r;
    doy6_r <= doy6_nxt;
    yb6_r  <= yb6_nxt;
    mp7_r  <= mp7_nxt;
    doy7_r <= doy6_r;
    yb7_r  <= yb6_r;
    civ_r  <= civ_nxt;
  end

  assign civ = civ_r;

endmodule
`default_nettype wire

/* test/epoch_msec_to_utc_calendar_test.sv */
`default_nettype none
module epoch_msec_to_utc_calendar_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned END_OF_9999_MS = 64'd253402300800000;
  localparam longint unsigned MS_IN_DAY      = 64'd86400000;
  localparam longint unsigned DAYS_IN_RANGE  = 64'd2932897;
  localparam longint unsigned MAX_TS         = 64'hFFFF_FFFF_FFFF;
  localparam int              DRAIN_CYCLES   = 20;
  localparam int              CYCLE_LIMIT    = 200000;
  localparam int              PRINT_CAP      = 200;

  typedef struct packed {
    logic [47:0] ts;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  millisecond;
    logic        valid;
  } utc_date_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic [47:0] in_timestamp_ms;
  logic        busy;
  logic        out_valid;
  logic [13:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;
  logic [9:0]  out_millisecond;
  logic        out_valid_res;

  utc_date_t pending_dates[$];
  int        n_sent;
  int        n_beyond;
  int        n_checked;
  int        n_errors;
  int        cycle_count;
  int        no_idle_left;

  epoch_msec_to_utc_calendar i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .in_timestamp_ms (in_timestamp_ms),
    .busy            (busy),
    .out_valid       (out_valid),
    .out_year        (out_year),
    .out_month       (out_month),
    .out_day         (out_day),
    .out_hour        (out_hour),
    .out_minute      (out_minute),
    .out_second      (out_second),
    .out_millisecond (out_millisecond),
    .out_valid_res   (out_valid_res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Civil date and time of day from a timestamp, eras of 400 years counted from 0000-03-01
  function automatic utc_date_t to_utc_date(input logic [47:0] ts);
    longint unsigned ms, secs, days, sod, z, era, doe, yoe, doy, mp, yr, mon;
    utc_date_t r;
    r = '0;
    r.ts = ts;
    ms = 64'(ts);
    if (ms >= END_OF_9999_MS) return r;
    secs = ms / 1000;
    days = secs / 86400;
    sod  = secs % 86400;
    z    = days + 719468;
    era  = z / 146097;
    doe  = z - era * 146097;
    yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp   = (5 * doy + 2) / 153;
    mon  = (mp < 10) ? mp + 3 : mp - 9;
    yr   = yoe + era * 400 + ((mon <= 2) ? 1 : 0);
    r.year        = 14'(yr);
    r.month       = 4'(mon);
    r.day         = 5'(doy - (153 * mp + 2) / 5 + 1);
    r.hour        = 5'(sod / 3600);
    r.minute      = 6'((sod / 60) % 60);
    r.second      = 6'(sod % 60);
    r.millisecond = 10'(ms % 1000);
    r.valid       = 1'b1;
    return r;
  endfunction

  function automatic logic [47:0] rand_ts_below(input longint unsigned bound);
    longint unsigned r;
    r = {$urandom, $urandom};
    return 48'(r % bound);
  endfunction

  // Random gap per request, with occasional stretches of back-to-back requests
  function automatic int pick_gap();
    if (no_idle_left > 0) begin
      no_idle_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) no_idle_left = $urandom_range(10, 40);
    return $urandom_range(0, 8);
  endfunction

  task automatic report_mismatch(input string what, input logic [47:0] ts,
                                 input longint unsigned got, input longint unsigned want);
    n_errors++;
    if (n_errors <= PRINT_CAP)
      $display("MISMATCH %s ts=%0d got=%0d want=%0d", what, ts, got, want);
  endtask

  task automatic check_field(input string what, input logic [47:0] ts,
                             input longint unsigned got, input longint unsigned want);
    if (got != want) report_mismatch(what, ts, got, want);
  endtask

  task automatic send_timestamp(input logic [47:0] ts, input int gap);
    utc_date_t want;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start           <= 1'b1;
    in_timestamp_ms <= ts;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = to_utc_date(ts);
    pending_dates.push_back(want);
    n_sent++;
    if (!want.valid) n_beyond++;
  endtask

  // Hold off new requests until every outstanding conversion has come back
  task automatic drain_pending();
    @(negedge clk);
    start <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed_edges();
    logic [47:0] edge_ts[$];
    edge_ts = '{48'd0, 48'd999, 48'd1000, 48'd59999, 48'd3599999, 48'd86399999,
                48'd86400000, 48'd31535999999, 48'd31536000000, 48'd68169600000,
                48'd951782400000, 48'd951868799999, 48'd951868800000,
                48'd2147483647000, 48'd2147483648000, 48'd4107542399999,
                48'd4107542400000, 48'd13574563200000,
                48'(END_OF_9999_MS - 1), 48'(END_OF_9999_MS), 48'(END_OF_9999_MS + 1),
                48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'(MAX_TS)};
    foreach (edge_ts[i]) send_timestamp(edge_ts[i], pick_gap());
  endtask

  task automatic test_random_dates(input int n);
    repeat (n) send_timestamp(rand_ts_below(END_OF_9999_MS), pick_gap());
  endtask

  // Midnight crossings land on month, year and century ends at random
  task automatic test_day_rollovers(input int n);
    longint unsigned days, offs;
    repeat (n) begin
      days = {$urandom, $urandom} % DAYS_IN_RANGE;
      offs = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 2)
                                         : MS_IN_DAY - 1 - $urandom_range(0, 2);
      send_timestamp(48'(days * MS_IN_DAY + offs), pick_gap());
    end
  endtask

  task automatic test_beyond_9999(input int n);
    logic [47:0] ts;
    repeat (n) begin
      case ($urandom_range(0, 2))
        0: ts = 48'(END_OF_9999_MS - 1 - $urandom_range(0, 200000));
        1: ts = 48'(END_OF_9999_MS + $urandom_range(0, 200000));
        default: ts = 48'({$urandom, $urandom});
      endcase
      send_timestamp(ts, pick_gap());
    end
  endtask

  task automatic test_back_to_back(input int n);
    repeat (n) send_timestamp(48'({$urandom, $urandom}), 0);
  endtask

  always @(posedge clk) begin : check_results
    utc_date_t want;
    if (rst_n && out_valid) begin
      if (pending_dates.size() == 0) begin
        report_mismatch("unrequested result", 48'd0, out_year, 0);
      end else begin
        want = pending_dates.pop_front();
        n_checked++;
        check_field("year", want.ts, out_year, want.year);
        check_field("month", want.ts, out_month, want.month);
        check_field("day", want.ts, out_day, want.day);
        check_field("hour", want.ts, out_hour, want.hour);
        check_field("minute", want.ts, out_minute, want.minute);
        check_field("second", want.ts, out_second, want.second);
        check_field("millisecond", want.ts, out_millisecond, want.millisecond);
        check_field("valid_res", want.ts, out_valid_res, want.valid);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d requests outstanding", pending_dates.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_timestamp_ms = '0;
    n_sent          = 0;
    n_beyond        = 0;
    n_checked       = 0;
    n_errors        = 0;
    cycle_count     = 0;
    no_idle_left    = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    drain_pending();
    test_random_dates(700);
    test_day_rollovers(250);
    drain_pending();
    test_beyond_9999(200);
    test_back_to_back(200);
    drain_pending();

    $display("Sent %0d timestamps (%0d past year 9999), %0d results checked",
             n_sent, n_beyond, n_checked);
    $display("Covered field extremes, leap and century days, midnight crossings, range end");
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
rtl/core/emuc_pkg.sv
rtl/core/emuc_tod.sv
rtl/core/emuc_civil.sv
rtl/core/epoch_msec_to_utc_calendar.sv
test/epoch_msec_to_utc_calendar_test.sv
